@@ hw/rtl/plr_pkg.sv @@
// Shared types, codes and constants for the patterned line rasterizer.
package plr_pkg;

  localparam int COORD_BITS_DEF = 16;
  localparam int COUNT_BITS_DEF = 10;
  localparam int RUN_LEN_W      = 10;
  localparam int COLOR_W        = 32;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 3;
  localparam int DD_RUN_W       = 5;

  localparam logic [RUN_LEN_W-1:0] DASH_LEN_RST = RUN_LEN_W'(8);
  localparam logic [RUN_LEN_W-1:0] GAP_LEN_RST  = RUN_LEN_W'(4);

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    MODE_SOLID   = 2'd0,
    MODE_DASHED  = 2'd1,
    MODE_DASHDOT = 2'd2
  } mode_t;

  typedef enum logic {
    REG_DASH_LEN = 1'b0,
    REG_GAP_LEN  = 1'b1
  } reg_idx_t;

  // Dash-dot run lengths: 18 on, 5 off, 5 on, 5 off.
  function automatic logic [DD_RUN_W-1:0] dd_run_len(input logic [1:0] phase);
    logic [DD_RUN_W-1:0] len;
    case (phase)
      2'd0:    len = DD_RUN_W'(18);
      default: len = DD_RUN_W'(5);
    endcase
    return len;
  endfunction

  function automatic logic dd_draw(input logic [1:0] phase);
    return ~phase[0];
  endfunction

endpackage

@@ hw/rtl/patterned_line_rasterizer_unit.sv @@
// Patterned line rasterizer: Bresenham stepper with solid, dashed and dash-dot patterns.
//
// Usage:
//   The input channel (in_valid / in_stall) takes one beat per item. A load beat
//   (in_operation = load) latches both endpoints, the pattern mode and the colour
//   and returns nothing. Each step beat returns one pixel beat on the output
//   channel (out_valid / out_stall) carrying coordinates, colour, a visible flag
//   from the pattern and a last flag at the endpoint; after the last pixel the
//   unit goes idle and further step beats return nothing.
//   A beat passes the input register, then the stepper logic feeding the output
//   register. One beat per cycle is sustained while the receiver does not stall;
//   the stepper and pattern state update once per beat.
//   When the receiver stalls, the output register holds its beat and the input
//   register fills, after which in_stall rises; load beats still drain.
//   The user must write dash and gap lengths over the APB port only while the unit is idle;
//   the unit does not enforce it. Reset (rst_n low, synchronous) empties both
//   registers, goes idle and sets dash length 8 and gap length 4.
module patterned_line_rasterizer_unit #(
  parameter int COORD_BITS = plr_pkg::COORD_BITS_DEF,
  parameter int COUNT_BITS = plr_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic signed [COORD_BITS-1:0]   in_line_x0,
  input  logic signed [COORD_BITS-1:0]   in_line_y0,
  input  logic signed [COORD_BITS-1:0]   in_line_x1,
  input  logic signed [COORD_BITS-1:0]   in_line_y1,
  input  logic [1:0]                     in_pattern_mode,
  input  logic [plr_pkg::COLOR_W-1:0]    in_pixel_color,
  // output channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [COORD_BITS-1:0]   out_pix_x,
  output logic signed [COORD_BITS-1:0]   out_pix_y,
  output logic [plr_pkg::COLOR_W-1:0]    out_pix_color,
  output logic                           out_visible,
  output logic                           out_last,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [plr_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [plr_pkg::APB_DATA_W-1:0] pwdata,
  output logic [plr_pkg::APB_DATA_W-1:0] prdata,
  output logic                           pready
);
  import plr_pkg::*;

  localparam int DELTA_W = COORD_BITS + 1;
  localparam int ERR_W   = COORD_BITS + 3;
  localparam int E2_W    = ERR_W + 1;
  localparam int CMP_W   = (COUNT_BITS > RUN_LEN_W) ? COUNT_BITS : RUN_LEN_W;

  // ---------------- configuration ----------------
  logic [RUN_LEN_W-1:0] dash_length_r, gap_length_r;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dash_length_r <= DASH_LEN_RST;
      gap_length_r  <= GAP_LEN_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_DASH_LEN: dash_length_r <= pwdata[RUN_LEN_W-1:0];
        REG_GAP_LEN:  gap_length_r  <= pwdata[RUN_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DASH_LEN: prdata = APB_DATA_W'(dash_length_r);
      REG_GAP_LEN:  prdata = APB_DATA_W'(gap_length_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------- input register ----------------
  logic                         s1_valid_r;
  op_t                          s1_op_r;
  logic signed [COORD_BITS-1:0] s1_x0_r, s1_y0_r, s1_x1_r, s1_y1_r;
  logic [1:0]                   s1_mode_r;
  logic [COLOR_W-1:0]           s1_color_r;
  logic                         in_accept, s1_adv, s1_emits, can_adv, out_taken;

  // ---------------- line state ----------------
  logic signed [COORD_BITS-1:0] cur_x_r, cur_y_r, target_x_r, target_y_r;
  logic [DELTA_W-1:0]           abs_dx_r, abs_dy_r;
  logic                         dir_x_neg_r, dir_y_neg_r;
  logic signed [ERR_W-1:0]      err_term_r;
  logic [COUNT_BITS-1:0]        run_count_r;
  logic                         drawing_on_r;
  logic [1:0]                   dash_phase_r;
  logic [1:0]                   mode_held_r;
  logic [COLOR_W-1:0]           color_held_r;
  logic                         busy_r;

  assign out_taken = out_valid & ~out_stall;
  assign can_adv   = ~out_valid | ~out_stall;
  assign s1_emits  = (s1_op_r == OP_STEP) & busy_r;
  assign s1_adv    = s1_valid_r & (can_adv | ~s1_emits);
  assign in_stall  = s1_valid_r & ~s1_adv;
  assign in_accept = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r    <= op_t'(in_operation);
      s1_x0_r    <= in_line_x0;
      s1_y0_r    <= in_line_y0;
      s1_x1_r    <= in_line_x1;
      s1_y1_r    <= in_line_y1;
      s1_mode_r  <= in_pattern_mode;
      s1_color_r <= in_pixel_color;
    end
  end

  // ---------------- load set-up ----------------
  logic signed [DELTA_W-1:0] ld_x0, ld_y0, ld_x1, ld_y1;
  logic [DELTA_W-1:0]        ld_dx, ld_dy;

  always_comb begin
    ld_x0 = DELTA_W'(s1_x0_r);
    ld_y0 = DELTA_W'(s1_y0_r);
    ld_x1 = DELTA_W'(s1_x1_r);
    ld_y1 = DELTA_W'(s1_y1_r);
    ld_dx = (ld_x1 > ld_x0) ? DELTA_W'(ld_x1 - ld_x0) : DELTA_W'(ld_x0 - ld_x1);
    ld_dy = (ld_y1 > ld_y0) ? DELTA_W'(ld_y1 - ld_y0) : DELTA_W'(ld_y0 - ld_y1);
  end

  // ---------------- step logic ----------------
  logic                         is_last, vis;
  logic signed [E2_W-1:0]       e2, dx_e, dy_e;
  logic                         step_x, step_y;
  logic signed [ERR_W-1:0]      err_nxt;
  logic signed [COORD_BITS-1:0] x_nxt, y_nxt;
  logic [COUNT_BITS-1:0]        run_inc, run_nxt;
  logic [CMP_W-1:0]             run_limit;
  logic                         run_done, drawing_nxt;
  logic [1:0]                   phase_nxt;

  always_comb begin
    is_last = (cur_x_r == target_x_r) && (cur_y_r == target_y_r);
    case (mode_held_r)
      MODE_DASHED:  vis = drawing_on_r;
      MODE_DASHDOT: vis = dd_draw(dash_phase_r);
      default:      vis = 1'b1;
    endcase

    e2     = E2_W'(err_term_r) <<< 1;
    dx_e   = $signed(E2_W'(abs_dx_r));
    dy_e   = $signed(E2_W'(abs_dy_r));
    step_x = e2 > -dy_e;
    step_y = e2 < dx_e;

    err_nxt = err_term_r;
    if (step_x) err_nxt = ERR_W'(err_nxt - $signed(ERR_W'(abs_dy_r)));
    if (step_y) err_nxt = ERR_W'(err_nxt + $signed(ERR_W'(abs_dx_r)));

    x_nxt = cur_x_r;
    if (step_x) x_nxt = dir_x_neg_r ? COORD_BITS'(cur_x_r - 1'b1)
                                    : COORD_BITS'(cur_x_r + 1'b1);
    y_nxt = cur_y_r;
    if (step_y) y_nxt = dir_y_neg_r ? COORD_BITS'(cur_y_r - 1'b1)
                                    : COORD_BITS'(cur_y_r + 1'b1);

    run_inc = COUNT_BITS'(run_count_r + 1'b1);
    case (mode_held_r)
      MODE_DASHED:  run_limit = drawing_on_r ? CMP_W'(dash_length_r) : CMP_W'(gap_length_r);
      MODE_DASHDOT: run_limit = CMP_W'(dd_run_len(dash_phase_r));
      default:      run_limit = '0;
    endcase
    run_done    = CMP_W'(run_inc) >= run_limit;
    run_nxt     = run_count_r;
    drawing_nxt = drawing_on_r;
    phase_nxt   = dash_phase_r;
    case (mode_held_r)
      MODE_DASHED: begin
        run_nxt = run_done ? '0 : run_inc;
        if (run_done) drawing_nxt = ~drawing_on_r;
      end
      MODE_DASHDOT: begin
        run_nxt = run_done ? '0 : run_inc;
        if (run_done) phase_nxt = 2'(dash_phase_r + 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      target_x_r   <= '0;
      target_y_r   <= '0;
      abs_dx_r     <= '0;
      abs_dy_r     <= '0;
      dir_x_neg_r  <= 1'b0;
      dir_y_neg_r  <= 1'b0;
      err_term_r   <= '0;
      run_count_r  <= '0;
      drawing_on_r <= 1'b1;
      dash_phase_r <= '0;
      mode_held_r  <= '0;
      color_held_r <= '0;
      busy_r       <= 1'b0;
    end else if (s1_adv) begin
      if (s1_op_r == OP_LOAD) begin
        cur_x_r      <= s1_x0_r;
        cur_y_r      <= s1_y0_r;
        target_x_r   <= s1_x1_r;
        target_y_r   <= s1_y1_r;
        abs_dx_r     <= ld_dx;
        abs_dy_r     <= ld_dy;
        dir_x_neg_r  <= ~(s1_x0_r < s1_x1_r);
        dir_y_neg_r  <= ~(s1_y0_r < s1_y1_r);
        err_term_r   <= ERR_W'($signed(ERR_W'(ld_dx)) - $signed(ERR_W'(ld_dy)));
        run_count_r  <= '0;
        drawing_on_r <= 1'b1;
        dash_phase_r <= '0;
        mode_held_r  <= s1_mode_r;
        color_held_r <= s1_color_r;
        busy_r       <= 1'b1;
      end else if (busy_r) begin
        if (is_last) begin
          busy_r <= 1'b0;
        end else begin
          cur_x_r      <= x_nxt;
          cur_y_r      <= y_nxt;
          err_term_r   <= err_nxt;
          run_count_r  <= run_nxt;
          drawing_on_r <= drawing_nxt;
          dash_phase_r <= phase_nxt;
        end
      end
    end
  end

  // ---------------- output register ----------------
  logic                         out_valid_r;
  logic signed [COORD_BITS-1:0] out_pix_x_r, out_pix_y_r;
  logic [COLOR_W-1:0]           out_pix_color_r;
  logic                         out_visible_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_emits) begin
      out_valid_r <= 1'b1;
    end else if (out_taken) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emits) begin
      out_pix_x_r     <= cur_x_r;
      out_pix_y_r     <= cur_y_r;
      out_pix_color_r <= color_held_r;
      out_visible_r   <= vis;
      out_last_r      <= is_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pix_x     = out_pix_x_r;
  assign out_pix_y     = out_pix_y_r;
  assign out_pix_color = out_pix_color_r;
  assign out_visible   = out_visible_r;
  assign out_last      = out_last_r;

  // ---------------- assertions ----------------
  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_emits && is_last) |=> !busy_r)
    else $error("line still busy after last pixel");

  a_solid_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && s1_emits && (mode_held_r == MODE_SOLID)) |=> out_visible_r)
    else $error("solid pattern produced hidden pixel");

  a_phase_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_held_r != MODE_DASHDOT) |-> (dash_phase_r == 2'd0))
    else $error("dash-dot phase moved outside dash-dot mode");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_emits && out_valid_r))
    else $error("input stalled without a blocked pixel");

endmodule
